>>> rtl/assert_macros.svh
// shared assertion macros for the page table walker checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is asserted
`define PTW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// clocked assertion that also holds during reset
`define PTW_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ptw_pkg.sv
`timescale 1ns / 1ps

package ptw_pkg;

	localparam int VPN_W      = 45;
	localparam int PPN_W      = 52;
	localparam int ENTRY_W    = PPN_W + 1;
	localparam int MODE_W     = 2;
	localparam int STATUS_W   = 2;
	localparam int ROOT_W     = 6;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int REG_IDX_W  = CFG_ADDR_W - 2;

	typedef logic [MODE_W-1:0]    mode_t;
	typedef logic [STATUS_W-1:0]  status_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	// operation codes, the unused code behaves as a query
	localparam mode_t MODE_QUERY = 2'd0;
	localparam mode_t MODE_MAP   = 2'd1;
	localparam mode_t MODE_UNMAP = 2'd2;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_NOMAP = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	localparam reg_idx_t REG_ROOT_FRAME = 1'b0;

endpackage

>>> rtl/ptw_if.sv
`timescale 1ns / 1ps

interface ptw_req_if import ptw_pkg::*; ();
	logic               valid;
	logic               ready;
	mode_t              mode;
	logic [VPN_W-1:0]   vpn;
	logic [PPN_W-1:0]   ppn;

	modport source (output valid, output mode, output vpn, output ppn, input ready);
	modport sink   (input valid, input mode, input vpn, input ppn, output ready);
endinterface

interface ptw_rsp_if import ptw_pkg::*; ();
	logic               valid;
	logic               ready;
	status_t            status;
	logic [PPN_W-1:0]   ppn_res;

	modport source (output valid, output status, output ppn_res, input ready);
	modport sink   (input valid, input status, input ppn_res, output ready);
endinterface

>>> rtl/multilevel_page_table_walker_top.sv
`timescale 1ns / 1ps

// channel   | dir | handshake        | payload
// ----------+-----+------------------+---------------------------------
// req       | in  | valid / ready    | mode, vpn, ppn
// rsp       | out | valid / ready    | status, ppn_res
// apb       | in  | psel / penable   | paddr, pwdata, prdata (root_frame)
//
// after reset a clearing pass writes zero to all FRAMES * 2^INDEX_BITS entries
// (32768 entries at the defaults); req.ready stays low until it ends
// a walk runs the modulo unit and one ram read per level visited, then loads
// the response; a FRAMES that is not a power of two makes the modulo unit
// iterate over the pointer, and each new table a map allocates is zeroed
// through the single ram write port before it is linked
// one transaction is walked at a time; the response sits in an output register,
// so a stalled rsp only holds the walker once the next walk has finished
module multilevel_page_table_walker_top import ptw_pkg::*; #(
	parameter int FRAMES     = 64,
	parameter int LEVELS     = 5,
	parameter int INDEX_BITS = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ptw_req_if.sink               req,
	ptw_rsp_if.source             rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int FRAME_W   = $clog2(FRAMES);
	localparam int DEPTH     = FRAMES * (2 ** INDEX_BITS);
	localparam int ADDR_W    = FRAME_W + INDEX_BITS;
	localparam int NF_W      = $clog2(FRAMES + 1);
	localparam int LVL_W     = $clog2(LEVELS);
	localparam int WALK_BITS = LEVELS * INDEX_BITS;

	localparam logic [ADDR_W-1:0]     LAST_ADDR  = ADDR_W'(DEPTH - 1);
	localparam logic [NF_W-1:0]       FRAME_CAP  = NF_W'(FRAMES);
	localparam logic [LVL_W-1:0]      LEAF_LEVEL = LVL_W'(LEVELS - 1);
	localparam logic [INDEX_BITS-1:0] LAST_IDX   = '1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_EVAL,
		S_ZERO,
		S_LINK,
		S_RESP
	} state_t;

	state_t                 state_q;
	logic [ADDR_W-1:0]      sweep_q;      // clearing pass address
	logic [NF_W-1:0]        next_frame_q; // allocator, stops at FRAMES
	logic [ROOT_W-1:0]      root_frame_q;
	logic                   mod_start_q;

	// walk context
	mode_t                  mode_q;
	logic [PPN_W-1:0]       ppn_q;
	logic [WALK_BITS-1:0]   idx_q;        // remaining indices, current one on top
	logic [LVL_W-1:0]       level_q;
	logic [PPN_W-1:0]       ptr_q;        // raw frame pointer before reduction
	logic [FRAME_W-1:0]     frame_q;      // table frame of the current level
	logic [FRAME_W-1:0]     nf_q;         // frame being allocated
	logic [INDEX_BITS-1:0]  zidx_q;       // zeroing sweep index

	status_t                res_status_q;
	logic [PPN_W-1:0]       res_ppn_q;
	logic                   rsp_valid_q;
	status_t                rsp_status_q;
	logic [PPN_W-1:0]       rsp_ppn_q;

	logic                   fm_done;
	logic [FRAME_W-1:0]     fm_result;

	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_waddr;
	logic [ENTRY_W-1:0]     mem_wdata;
	logic [ADDR_W-1:0]      mem_raddr;
	logic [ENTRY_W-1:0]     mem_rdata;

	logic [WALK_BITS+VPN_W-1:0] vpn_ext;
	logic [INDEX_BITS-1:0]  cur_idx;
	logic [ADDR_W-1:0]      walk_addr;
	logic                   is_leaf;
	logic                   frames_out;
	logic                   cfg_wr;
	logic                   rsp_load;

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	assign cfg_wr = psel && penable && pwrite &&
		(paddr[CFG_ADDR_W-1:2] == REG_ROOT_FRAME);
	assign pready = 1'b1;
	assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_ROOT_FRAME) ?
		CFG_DATA_W'(root_frame_q) : '0;

	// ------------------------------------------------------------------
	// walk addressing
	// ------------------------------------------------------------------
	// vpn bits above the walked indices drop out, missing upper bits read as zero
	assign vpn_ext    = {{WALK_BITS{1'b0}}, req.vpn};
	assign cur_idx    = idx_q[WALK_BITS-1 -: INDEX_BITS];
	assign walk_addr  = {frame_q, cur_idx};
	assign is_leaf    = (level_q == LEAF_LEVEL);
	assign frames_out = (next_frame_q >= FRAME_CAP);

	// read issued as soon as the reduced frame is known, data lands in S_EVAL
	assign mem_raddr  = {(fm_done ? fm_result : frame_q), cur_idx};

	// shared modulo unit for every frame pointer on the walk
	ptw_fmod #(
		.FRAMES (FRAMES)
	) u_fmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start_q),
		.value  (ptr_q),
		.done   (fm_done),
		.result (fm_result)
	);

	ptw_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// single write port shared by clearing, zeroing, linking and leaf updates
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = walk_addr;
		mem_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
			end
			S_ZERO: begin
				mem_we    = 1'b1;
				mem_waddr = {nf_q, zidx_q};
			end
			S_LINK: begin
				// new table pointer, written after the frame is zeroed
				mem_we    = 1'b1;
				mem_wdata = {PPN_W'(nf_q), 1'b1};
			end
			S_EVAL: begin
				if (is_leaf && mode_q == MODE_MAP) begin
					mem_we    = 1'b1;
					mem_wdata = {ppn_q, 1'b1};
				end else if (is_leaf && mode_q == MODE_UNMAP) begin
					// only the valid bit goes, the ppn bits stay
					mem_we    = 1'b1;
					mem_wdata = {mem_rdata[ENTRY_W-1:1], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			sweep_q      <= '0;
			next_frame_q <= NF_W'(1);
			root_frame_q <= '0;
			mod_start_q  <= 1'b0;
			mode_q       <= MODE_QUERY;
			ppn_q        <= '0;
			idx_q        <= '0;
			level_q      <= '0;
			ptr_q        <= '0;
			frame_q      <= '0;
			nf_q         <= '0;
			zidx_q       <= '0;
			res_status_q <= ST_OK;
			res_ppn_q    <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_OK;
			rsp_ppn_q    <= '0;
		end else begin
			mod_start_q <= 1'b0;

			if (cfg_wr) begin
				root_frame_q <= pwdata[ROOT_W-1:0];
			end

			// output register: freed on acceptance, refilled by a finished walk
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (rsp_load) begin
				rsp_valid_q  <= 1'b1;
				rsp_status_q <= res_status_q;
				rsp_ppn_q    <= res_ppn_q;
			end

			unique case (state_q)
				S_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						mode_q      <= req.mode;
						ppn_q       <= req.ppn;
						idx_q       <= vpn_ext[WALK_BITS-1:0];
						level_q     <= '0;
						ptr_q       <= PPN_W'(root_frame_q);
						mod_start_q <= 1'b1;
						state_q     <= S_MOD;
					end
				end
				S_MOD: begin
					if (fm_done) begin
						frame_q <= fm_result;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (is_leaf) begin
						res_ppn_q <= '0;
						if (mode_q == MODE_MAP || mode_q == MODE_UNMAP) begin
							res_status_q <= ST_OK;
						end else if (mem_rdata[0]) begin
							res_status_q <= ST_OK;
							res_ppn_q    <= mem_rdata[ENTRY_W-1:1];
						end else begin
							res_status_q <= ST_NOMAP;
						end
						state_q <= S_RESP;
					end else if (mem_rdata[0]) begin
						// descend through a valid upper entry
						ptr_q       <= mem_rdata[ENTRY_W-1:1];
						idx_q       <= {idx_q[WALK_BITS-INDEX_BITS-1:0], {INDEX_BITS{1'b0}}};
						level_q     <= level_q + 1'b1;
						mod_start_q <= 1'b1;
						state_q     <= S_MOD;
					end else if (mode_q == MODE_MAP) begin
						if (frames_out) begin
							res_status_q <= ST_FULL;
							res_ppn_q    <= '0;
							state_q      <= S_RESP;
						end else begin
							nf_q         <= next_frame_q[FRAME_W-1:0];
							next_frame_q <= next_frame_q + 1'b1;
							zidx_q       <= '0;
							state_q      <= S_ZERO;
						end
					end else begin
						// unmap stops quietly, a query reports the missing entry
						res_status_q <= (mode_q == MODE_UNMAP) ? ST_OK : ST_NOMAP;
						res_ppn_q    <= '0;
						state_q      <= S_RESP;
					end
				end
				S_ZERO: begin
					zidx_q <= zidx_q + 1'b1;
					if (zidx_q == LAST_IDX) begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					ptr_q       <= PPN_W'(nf_q);
					idx_q       <= {idx_q[WALK_BITS-INDEX_BITS-1:0], {INDEX_BITS{1'b0}}};
					level_q     <= level_q + 1'b1;
					mod_start_q <= 1'b1;
					state_q     <= S_MOD;
				end
				S_RESP: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = rsp_status_q;
	assign rsp.ppn_res = rsp_ppn_q;

endmodule

>>> rtl/ptw_ram.sv
`timescale 1ns / 1ps

module ptw_ram #(
	parameter int WIDTH = 53,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/ptw_fmod.sv
`timescale 1ns / 1ps

// reduces a frame pointer modulo FRAMES
module ptw_fmod import ptw_pkg::*; #(
	parameter int FRAMES = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [PPN_W-1:0]          value,
	output logic                      done,
	output logic [$clog2(FRAMES)-1:0] result
);

	localparam int  FRAME_W = $clog2(FRAMES);
	localparam bit  POW2    = (FRAMES & (FRAMES - 1)) == 0;

	if (POW2) begin : g_mask
		logic                done_q;
		logic [FRAME_W-1:0]  res_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
				res_q  <= '0;
			end else begin
				done_q <= start;
				res_q  <= value[FRAME_W-1:0];
			end
		end

		assign done   = done_q;
		assign result = res_q;
	end else begin : g_iter
		// restoring remainder, STEP bits per cycle while busy
		localparam int STEP     = 4;
		localparam int NSTEPS   = PPN_W / STEP;
		localparam int CNT_W    = $clog2(NSTEPS);
		localparam logic [CNT_W-1:0]   LAST_STEP = CNT_W'(NSTEPS - 1);
		localparam logic [FRAME_W:0]   MODULUS   = (FRAME_W + 1)'(FRAMES);

		logic                busy_q;
		logic                done_q;
		logic [CNT_W-1:0]    cnt_q;
		logic [PPN_W-1:0]    val_q;
		logic [FRAME_W-1:0]  rem_q;
		logic [FRAME_W-1:0]  rem_n;
		logic [FRAME_W:0]    trial;

		always_comb begin
			rem_n = rem_q;
			trial = '0;
			for (int k = 0; k < STEP; k++) begin
				trial = {rem_n, val_q[PPN_W-1-k]};
				if (trial >= MODULUS) begin
					trial = trial - MODULUS;
				end
				rem_n = trial[FRAME_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				busy_q <= 1'b0;
				done_q <= 1'b0;
				cnt_q  <= '0;
				val_q  <= '0;
				rem_q  <= '0;
			end else begin
				done_q <= 1'b0;
				if (start) begin
					val_q  <= value;
					rem_q  <= '0;
					cnt_q  <= '0;
					busy_q <= 1'b1;
				end else if (busy_q) begin
					val_q <= {val_q[PPN_W-STEP-1:0], {STEP{1'b0}}};
					rem_q <= rem_n;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_STEP) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end

		assign done   = done_q;
		assign result = rem_q;
	end

endmodule

>>> rtl/ptw_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptw_checker import ptw_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input status_t          status,
	input logic [PPN_W-1:0] ppn_res
);

	// an accepted transaction moves the walker out of S_IDLE, so ready drops after it
	`PTW_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "ready held after accept")

	// a stalled response keeps its payload
	`PTW_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(ppn_res), "stalled response changed")

	`PTW_ASSERT(a_status_code, rsp_valid |-> (status == ST_OK || status == ST_NOMAP || status == ST_FULL), "illegal status code")

	// only a successful lookup carries a ppn
	`PTW_ASSERT(a_ppn_only_ok, rsp_valid && status != ST_OK |-> ppn_res == '0, "ppn on failed response")

endmodule

bind multilevel_page_table_walker_top ptw_checker u_ptw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.status    (rsp.status),
	.ppn_res   (rsp.ppn_res)
);
